>>> rtl/label_grow_window_pass_top_defines.svh
// Assertion macros for the label grow window pass block.
// Included by label_grow_window_pass_top.sv; needs i_clk and i_rst_n in scope.
`ifndef LABEL_GROW_WINDOW_PASS_TOP_DEFINES_SVH
`define LABEL_GROW_WINDOW_PASS_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LGWP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LGWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lgwp_pkg.sv
// Shared types and constants for the label grow window pass block.
// No dependencies; imported by label_grow_window_pass_top.
package lgwp_pkg;

    localparam int PIX_W          = 8;
    localparam int W_REG_W        = 11;
    localparam int H_REG_W        = 13;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;

    localparam logic [W_REG_W-1:0] W_RESET = 11'd1024;
    localparam logic [H_REG_W-1:0] H_RESET = 13'd1024;

    localparam logic [PIX_W-1:0] OBSTACLE   = 8'h00;
    localparam logic [PIX_W-1:0] UNASSIGNED = 8'hFF;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // per-pixel control carried with the word into the window stage
    typedef struct packed {
        logic emit;
        logic eof;
        logic skip_top;
        logic skip_bot;
        logic skip_left;
        logic skip_right;
    } t_ctl;

    function automatic logic is_label(input logic [PIX_W-1:0] v);
        is_label = (v != OBSTACLE) && (v != UNASSIGNED);
    endfunction

endpackage

>>> rtl/label_grow_window_pass_top.sv
// Throughput: one word per cycle in and out, sustained; s_axis_tready falls only while
// the output register holds a word that is not taken. A result is written to the output register
// when the item that completes its 3x3 window (width + 1 items after the pixel itself) leaves
// stage 1; fillers push out the last row. Reset (synchronous, active low)
// clears position counters, window, pipeline valids and restores 1024 x 1024; the line
// store is not cleared (no clearing pass) and stale entries only feed masked positions.
`include "label_grow_window_pass_top_defines.svh"

// One region-growing pass over a raster label map: 3x3 window, line store, APB setup.
// Depends on lgwp_pkg and label_grow_window_pass_top_defines.svh.
module label_grow_window_pass_top
    import lgwp_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel_value
    input  logic              s_axis_tuser,   // [0] is_filler
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [PIX_W-1:0]  m_axis_tdata,   // [7:0] out_value
    output logic              m_axis_tlast    // end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);        // column index
    localparam int WW = CW + 1;                   // column count
    localparam int RW = $clog2(MAX_HEIGHT + 2);   // rows run to height + 1 while flushing

    // ---------------- configuration ----------------
    logic [W_REG_W-1:0] r_img_w;
    logic [H_REG_W-1:0] r_img_h;
    logic               cfg_wr;
    logic [WW-1:0]      eff_w;
    logic [RW-1:0]      eff_h;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= W_RESET;
            r_img_h <= H_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_img_w <= pwdata[W_REG_W-1:0];
                REG_HEIGHT: r_img_h <= pwdata[H_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_img_w);
            REG_HEIGHT: prdata = APB_DW'(r_img_h);
            default:    prdata = '0;
        endcase
    end

    // zero acts as one, oversize clamps to the build maximum
    always_comb begin
        if (r_img_w == '0)
            eff_w = WW'(1);
        else if (32'(r_img_w) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(r_img_w);

        if (r_img_h == '0)
            eff_h = RW'(1);
        else if (32'(r_img_h) > 32'(MAX_HEIGHT))
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(r_img_h);
    end

    // ---------------- input position and window bookkeeping ----------------
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic             in_acc;
    logic             col_zero;
    logic             col_last;
    logic [RW-1:0]    h_plus1;
    logic [PIX_W-1:0] pix_in;
    t_ctl             ctl_in;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign col_zero = (r_col == '0);
    assign col_last = (({1'b0, r_col} + WW'(1)) == eff_w);
    assign h_plus1  = eff_h + RW'(1);

    // fillers, and anything past the frame's pixels, enter as obstacles
    assign pix_in = (!s_axis_tuser && (r_row < eff_h)) ? s_axis_tdata : OBSTACLE;

    // The result centered one row up and one column left of the incoming pixel;
    // at column zero that center wraps to the last column two rows up.
    always_comb begin
        ctl_in.emit       = (r_row >= RW'(2)) || ((r_row == RW'(1)) && !col_zero);
        ctl_in.skip_top   = col_zero ? (r_row == RW'(2)) : (r_row == RW'(1));
        ctl_in.skip_bot   = col_zero ? (r_row >= h_plus1) : (r_row >= eff_h);
        ctl_in.skip_left  = col_zero ? (eff_w == WW'(1)) : (r_col == CW'(1));
        ctl_in.skip_right = col_zero;
        ctl_in.eof        = ctl_in.emit && col_zero && (r_row == h_plus1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr || (in_acc && ctl_in.eof)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------- stage 1: line store read data plus item ----------------
    logic                 r_v1;
    logic [PIX_W-1:0]     r_pix1;
    logic [CW-1:0]        r_col1;
    t_ctl                 r_ctl1;
    logic                 move;

    // each entry packs {upper row, middle row} for one column
    logic [2*PIX_W-1:0]   r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]   r_rd;
    logic                 r_fwd;
    logic [2*PIX_W-1:0]   r_fwd_data;
    logic [PIX_W-1:0]     up_eff;
    logic [PIX_W-1:0]     mid_eff;

    assign move          = r_v1 && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_v1 || move;

    assign up_eff  = r_fwd ? r_fwd_data[2*PIX_W-1:PIX_W] : r_rd[2*PIX_W-1:PIX_W];
    assign mid_eff = r_fwd ? r_fwd_data[PIX_W-1:0]       : r_rd[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v1 <= 1'b0;
        else if (in_acc)
            r_v1 <= 1'b1;
        else if (move)
            r_v1 <= 1'b0;
    end

    // read on accept, write back when the item leaves stage 1;
    // same column back to back (width one, or frame restart) is forwarded
    always_ff @(posedge i_clk) begin
        if (move)
            r_line_mem[r_col1] <= {mid_eff, r_pix1};
        if (in_acc) begin
            r_rd       <= r_line_mem[r_col];
            r_fwd      <= move && (r_col1 == r_col);
            r_fwd_data <= {mid_eff, r_pix1};
            r_pix1     <= pix_in;
            r_col1     <= r_col;
            r_ctl1     <= ctl_in;
        end
    end

    // ---------------- window and result ----------------
    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] new_col [3];
    logic [PIX_W-1:0] res;

    assign new_col[0] = up_eff;
    assign new_col[1] = mid_eff;
    assign new_col[2] = r_pix1;

    // later positions in raster order win
    always_comb begin
        logic [PIX_W-1:0] v;
        logic             skip;
        res = r_win[5];
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                v    = (dc == 2) ? new_col[dr] : r_win[dr*3 + dc + 1];
                skip = ((dr == 0) && r_ctl1.skip_top)  || ((dr == 2) && r_ctl1.skip_bot) ||
                       ((dc == 0) && r_ctl1.skip_left) || ((dc == 2) && r_ctl1.skip_right);
                if ((r_win[5] == UNASSIGNED) && !skip && is_label(v))
                    res = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++)
                r_win[i] <= '0;
        end else if (move) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
                r_win[r*3 + 2] <= new_col[r];
            end
        end
    end

    // ---------------- output register ----------------
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (move && r_ctl1.emit)
            r_out_valid <= 1'b1;
        else if (m_axis_tready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (move && r_ctl1.emit) begin
            r_out_data <= res;
            r_out_last <= r_ctl1.eof;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ---------------- assertions ----------------
    `LGWP_ASSERT_NOW(a_col_range, 1'b1, ({1'b0, r_col} < eff_w),
        "input column beyond image width")
    `LGWP_ASSERT_NOW(a_row_range, 1'b1, (r_row <= h_plus1),
        "input row beyond flush row")
    `LGWP_ASSERT_NEXT(a_stage_hold, (r_v1 && !move),
        (r_v1 && $stable(r_pix1) && $stable(r_col1)),
        "stalled window stage item changed")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for label_grow_window_pass_top: label maps stream through the
// 3x3 growing pass and every output word is compared with a local model of the pass.
// Depends on lgwp_pkg and the label_grow_window_pass_top RTL.
module tb;
    import lgwp_pkg::*;

    localparam int CLK_HALF      = 4;       // 8 ns period
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;       // output register plus margin
    localparam int DRAIN_LIMIT   = 200000;  // cycles to wait for outstanding words
    localparam int PHASE_ITEMS   = 190;     // random words per idling phase
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int NO_LIMIT      = 1 << 30;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             eof;
    } t_grown_px;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata  = '0;   // [7:0] pixel_value
    logic              s_tuser  = 1'b0; // [0] is_filler
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [PIX_W-1:0]  m_tdata;         // [7:0] out_value
    logic              m_tlast;         // end_of_frame

    label_grow_window_pass_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model state of the growing pass
    // ------------------------------------------------------------------
    logic [W_REG_W-1:0] cfg_w;
    logic [H_REG_W-1:0] cfg_h;
    int unsigned        act_w;   // width after clamping 0 -> 1, > max -> max
    int unsigned        act_h;
    logic [PIX_W-1:0]   upper_line  [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]   middle_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]   win [9];     // 3x3 window, row-major, [8] is newest
    int unsigned        in_col;
    int unsigned        in_row;
    int unsigned        out_idx;

    t_grown_px grown_q[$];           // predicted words, oldest first
    int        fail_cnt      = 0;
    int        items_sent    = 0;
    int        src_idle_pct  = 0;
    int        snk_stall_pct = 0;
    int        hold_req      = 0;    // hold-off request for the receiver
    int        hold_left     = 0;

    // Register write side effects: store the field, reclamp, restart the frame.
    function automatic void model_write(input logic idx, input logic [APB_DW-1:0] val);
        if (idx == REG_WIDTH)
            cfg_w = val[W_REG_W-1:0];
        else
            cfg_h = val[H_REG_W-1:0];
        act_w   = (cfg_w == 0) ? 1 : (cfg_w > MAX_WIDTH_DEF)  ? MAX_WIDTH_DEF  : cfg_w;
        act_h   = (cfg_h == 0) ? 1 : (cfg_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : cfg_h;
        in_col  = 0;
        in_row  = 0;
        out_idx = 0;
    endfunction

    // One accepted input word: shift the window, update the line stores and,
    // once the window around the trailing pixel is complete, predict its label.
    function automatic void grow_pixel(input logic [PIX_W-1:0] px_in, input logic filler);
        int unsigned      slot, frame_px, seen, orow, ocol, dr, dc;
        logic [PIX_W-1:0] px, res, nb;
        bit               emit;
        t_grown_px        word;
        slot     = in_col % MAX_WIDTH_DEF;
        frame_px = act_w * act_h;
        seen     = in_row * act_w + in_col;
        // fillers, and anything past the frame's pixels, read as obstacle
        px = (!filler && seen < frame_px) ? px_in : OBSTACLE;
        for (dr = 0; dr < 3; dr++) begin
            win[dr*3]   = win[dr*3+1];
            win[dr*3+1] = win[dr*3+2];
        end
        win[2]            = upper_line[slot];
        win[5]            = middle_line[slot];
        win[8]            = px;
        upper_line[slot]  = middle_line[slot];
        middle_line[slot] = px;

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col >= 1) begin
            orow = in_row - 1;
            ocol = in_col - 1;
        end else begin
            orow = in_row - 2;
            ocol = act_w - 1;
        end
        in_col++;
        if (in_col >= act_w) begin
            in_col = 0;
            in_row++;
        end
        if (emit) begin
            res = win[4];
            if (win[4] == UNASSIGNED) begin
                // last labelled neighbor in raster order wins; off-image cells skipped
                for (dr = 0; dr < 3; dr++)
                    for (dc = 0; dc < 3; dc++)
                        if (!(dr == 0 && orow == 0) && !(dr == 2 && orow + 1 >= act_h) &&
                            !(dc == 0 && ocol == 0) && !(dc == 2 && ocol + 1 >= act_w)) begin
                            nb = win[dr*3+dc];
                            if (nb != OBSTACLE && nb != UNASSIGNED)
                                res = nb;
                        end
            end
            word.value = res;
            word.eof   = (out_idx + 1 >= frame_px);
            if (word.eof) begin
                in_col  = 0;
                in_row  = 0;
                out_idx = 0;
            end else begin
                out_idx++;
            end
            grown_q = {grown_q, word};
        end
    endfunction

    // Pixel mix: plenty of unassigned and obstacle cells so labels actually spread.
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0, 1, 2, 3: rand_pixel = UNASSIGNED;
            4, 5:       rand_pixel = OBSTACLE;
            9:          rand_pixel = PIX_W'($urandom_range(255));
            default:    rand_pixel = PIX_W'($urandom_range(254, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input stream driver. Called at any time; changes inputs on the falling
    // edge and returns right after the accepting rising edge. tvalid stays high
    // between back-to-back words, so it never gets two updates in one step.
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic filler);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= filler;
        do @(posedge i_clk); while (!s_tready);
        grow_pixel(px, filler);
        items_sent++;
    endtask

    task automatic stream_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    // Wait for every predicted word; optionally let the pipeline settle after.
    task automatic wait_results(input bit settle);
        int n;
        n = 0;
        while (grown_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (grown_q.size() != 0) begin
            $error("%0d expected words never arrived", grown_q.size());
            fail_cnt++;
            grown_q.delete();
        end
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Words [first, first+count) of a frame at the current geometry: pixels, then
    // width + 1 fillers. Noisy frames mix fillers into the pixels and pixels
    // into the flush.
    task automatic send_frame(input int first, input int count, input bit noisy);
        int  total, n;
        bit  fill;
        total = act_w * act_h + act_w + 1;
        for (n = first; n < total && n < first + count; n++) begin
            if (n < act_w * act_h)
                fill = noisy && ($urandom_range(19) == 0);
            else
                fill = !(noisy && ($urandom_range(3) == 0));
            send_pixel(rand_pixel(), fill);
        end
    endtask

    // ------------------------------------------------------------------
    // APB access: setup cycle, access cycle, sample at the pready edge.
    // ------------------------------------------------------------------
    task automatic apb_xfer(input logic idx, input logic wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] rd;
        apb_xfer(idx, 1'b0, '0, rd);
        if (rd !== want) begin
            $error("prdata reg %0d: expected %0d, got %0d", idx, want, rd);
            fail_cnt++;
        end
    endtask

    // Register writes happen only with the stream idle and all output drained.
    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] rd;
        stream_idle();
        wait_results(1'b1);
        apb_xfer(idx, 1'b1, val, rd);
        model_write(idx, val);
        check_reg(idx, (idx == REG_WIDTH) ? APB_DW'(val[W_REG_W-1:0])
                                          : APB_DW'(val[H_REG_W-1:0]));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off counted here on request.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : sink_ready
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Output checker: each accepted word against the oldest prediction.
    always @(posedge i_clk) begin : check_words
        t_grown_px want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (grown_q.size() == 0) begin
                $error("unexpected output word: out_value %0d end_of_frame %0b",
                       m_tdata, m_tlast);
                fail_cnt++;
            end else begin
                want = grown_q.pop_front();
                if (m_tdata !== want.value) begin
                    $error("out_value: expected %0d, got %0d", want.value, m_tdata);
                    fail_cnt++;
                end
                if (m_tlast !== want.eof) begin
                    $error("end_of_frame: expected %0b, got %0b", want.eof, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        check_reg(REG_WIDTH, APB_DW'(W_RESET));
        check_reg(REG_HEIGHT, APB_DW'(H_RESET));
    endtask

    // Hand-built frames: label extremes, priority of the last neighbor,
    // filler inside the frame, pixels in the flush, isolated unassigned cells.
    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        send_pixel(8'd10, 1'b0);
        send_pixel(UNASSIGNED, 1'b0);
        send_pixel(8'd20, 1'b0);
        send_pixel(UNASSIGNED, 1'b0);
        send_pixel(UNASSIGNED, 1'b0);  // center: sees 10, 20, 254, 1 -> last wins
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'hA5, 1'b1);       // filler in the frame reads as obstacle
        send_pixel(UNASSIGNED, 1'b0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'd77, 1'b0);       // pixel after the frame acts as filler
        send_pixel(8'h00, 1'b1);
        send_pixel(8'd200, 1'b0);
        // 1x1 frame: every neighbor is off the image
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 1);
        send_pixel(UNASSIGNED, 1'b0);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b1);
        // 2x2 with no label anywhere: unassigned stays unassigned
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, 2);
        send_pixel(UNASSIGNED, 1'b0);
        send_pixel(UNASSIGNED, 1'b0);
        send_pixel(UNASSIGNED, 1'b0);
        send_pixel(OBSTACLE, 1'b0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h00, 1'b1);
    endtask

    // Random geometry and content under each idling mix; mostly whole frames,
    // some truncated or noisy ones and stray words between them.
    task automatic test_random_frames();
        int phase, start, full, budget;
        logic [APB_DW-1:0] w, h;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
                default: begin src_idle_pct = 8; snk_stall_pct = 8; end
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                case ($urandom_range(15))
                    0:       w = 0;
                    1, 2:    w = $urandom_range(40, 13);
                    default: w = $urandom_range(12, 1);
                endcase
                case ($urandom_range(15))
                    0:       h = 0;
                    1:       h = $urandom_range(8191, 4097);
                    default: h = $urandom_range(8, 1);
                endcase
                write_reg(REG_WIDTH, w);
                write_reg(REG_HEIGHT, h);
                repeat ($urandom_range(3, 1)) begin
                    full = act_w * act_h + act_w + 1;
                    if (full > 300)
                        budget = $urandom_range(300, 60);  // large frame: prefix only
                    else if ($urandom_range(7) == 0)
                        budget = $urandom_range(full, 1);  // cut short
                    else
                        budget = full;
                    // keep the phase near its word budget
                    if (budget > PHASE_ITEMS - (items_sent - start))
                        budget = PHASE_ITEMS - (items_sent - start);
                    send_frame(0, budget, $urandom_range(3) == 0);
                    if ($urandom_range(9) == 0)
                        send_pixel(rand_pixel(), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    // Register extremes: clamped width and height (a prefix shorter than one
    // row, so nothing may come out), tallest frame and zero sizes.
    task automatic test_size_extremes();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 8191);
        send_frame(0, 24, 1'b0);
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, MAX_HEIGHT_DEF);
        send_frame(0, 40, 1'b1);
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        repeat (4) send_frame(0, NO_LIMIT, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering, so the block stalls
    // its input; then the sender pauses mid-frame until all output is out.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_reg(REG_WIDTH, 6);
        write_reg(REG_HEIGHT, 5);
        @(posedge i_clk);
        hold_req = HOLD_CYCLES;
        send_frame(0, NO_LIMIT, 1'b0);
        send_frame(0, 20, 1'b0);
        stream_idle();
        wait_results(1'b0);
        send_frame(20, NO_LIMIT, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : run
        cfg_w   = W_RESET;
        cfg_h   = H_RESET;
        act_w   = W_RESET;
        act_h   = H_RESET;
        in_col  = 0;
        in_row  = 0;
        out_idx = 0;
        foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed();
        test_random_frames();
        test_size_extremes();
        test_backpressure();

        stream_idle();
        wait_results(1'b1);
        if (fail_cnt == 0)
            $display("label_grow_window_pass_top regression: pass");
        else
            $display("label_grow_window_pass_top regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin : watchdog
        #50_000_000;
        $display("label_grow_window_pass_top regression: fail");
        $finish;
    end

endmodule
